/* design/midi_note_gate_timers_macros.svh */
// ----------------------------------------------------------------------------
// MIDI note gate timers: assertion macros
// Concurrent check helpers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_GATE_TIMERS_MACROS_SVH
`define MIDI_NOTE_GATE_TIMERS_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define MNGT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MNGT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MNGT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define MNGT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* design/mngt_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI note gate timers: package
// Shared widths, codes and the command type passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mngt_pkg;

   localparam int NOTE_COUNT_DEF  = 128;
   localparam int TIME_BITS_DEF   = 24;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int NOTE_FIELD_BITS = 7;
   localparam int DURATION_BITS   = 24;
   localparam int ELAPSED_BITS    = 16;
   localparam int CMD_TIME_BITS   = 32;
   localparam int MASK_BITS       = 64;
   localparam int MASK_TOTAL      = 2 * MASK_BITS;

   localparam logic [6:0] NOTE_VELOCITY = 7'd100;

   localparam logic ACTION_PLAY  = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;
   localparam logic KIND_NOTE_ON = 1'b0;
   localparam logic KIND_MASK    = 1'b1;
   localparam logic BANK_LOW     = 1'b0;
   localparam logic BANK_HIGH    = 1'b1;

   typedef struct packed {
      logic                       is_tick;
      logic [NOTE_FIELD_BITS-1:0] note;
      logic [CMD_TIME_BITS-1:0]   duration;  // already clamped to the timer width
      logic [ELAPSED_BITS-1:0]    elapsed;
   } cmd_type;

endpackage

/* design/midi_note_gate_timers.sv */
// A play item passes the front register and the queue; the engine then reads its
// timer (PLAY_RD, PLAY_EX) and registers a note-on if the note was silent. A tick item
// sweeps the timer memory one note per cycle (one read and one write port), then sends
// its low and high bank masks. The engine works on one item at a time; a short queue
// lets new items enter meanwhile.
// Reset (synchronous, active high) silences every note at once via per-note valid bits.
// ----------------------------------------------------------------------------
// MIDI note gate timers
// Per-note remaining-time counters: plays start notes, ticks report expiries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_note_gate_timers_macros.svh"

module midi_note_gate_timers
   import mngt_pkg::*;
#(
   parameter int NOTE_COUNT  = NOTE_COUNT_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request items
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  logic [NOTE_FIELD_BITS-1:0] req_note,
   input  logic [DURATION_BITS-1:0]   req_duration,
   input  logic [ELAPSED_BITS-1:0]    req_elapsed,
   // result items
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic [NOTE_FIELD_BITS-1:0] rsp_note_number,
   output logic [6:0]                 rsp_velocity,
   output logic                       rsp_bank,
   output logic [MASK_BITS-1:0]       rsp_expired_mask,
   output logic                       rsp_last
);

   // Front end: register stage that drops plays for notes outside the
   // table and clamps the duration to the timer width.
   logic    front_valid, front_ready;
   cmd_type front_cmd;

   // Queue output toward the timer engine.
   logic    eng_valid, eng_ready;
   cmd_type eng_cmd;

   mngt_front #(
      .NOTE_COUNT (NOTE_COUNT),
      .TIME_BITS  (TIME_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_note     (req_note),
      .req_duration (req_duration),
      .req_elapsed  (req_elapsed),
      .cmd_valid    (front_valid),
      .cmd_ready    (front_ready),
      .cmd          (front_cmd)
   );

   mngt_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (eng_valid),
      .pop_ready  (eng_ready),
      .pop_cmd    (eng_cmd)
   );

   // Timer engine: one command at a time. A play reads its note's timer,
   // emits a note-on if it was zero and raises it to the duration. A tick
   // pipelines read of note i with write-back of note i-1, collects the
   // expiry bits, then sends the low and high bank masks in order.
   mngt_back #(
      .NOTE_COUNT (NOTE_COUNT),
      .TIME_BITS  (TIME_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (eng_valid),
      .cmd_ready        (eng_ready),
      .cmd              (eng_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_note_number  (rsp_note_number),
      .rsp_velocity     (rsp_velocity),
      .rsp_bank         (rsp_bank),
      .rsp_expired_mask (rsp_expired_mask),
      .rsp_last         (rsp_last)
   );

   // A note-on always carries the fixed velocity, no mask, and ends its item.
   `MNGT_ASSERT_IMPLY(a_note_on_form, clock, reset,
      rsp_valid && (rsp_kind == KIND_NOTE_ON),
      (rsp_velocity == NOTE_VELOCITY) && rsp_last && (rsp_expired_mask == '0),
      "note-on item malformed")
   // Only the high bank mask closes a tick.
   `MNGT_ASSERT_IMPLY(a_mask_last, clock, reset,
      rsp_valid && (rsp_kind == KIND_MASK),
      rsp_last == rsp_bank,
      "mask item last flag wrong")
   // The high bank follows the low bank straight away.
   `MNGT_ASSERT_NEXT(a_bank_order, clock, reset,
      rsp_valid && rsp_ready && (rsp_kind == KIND_MASK) && (rsp_bank == BANK_LOW),
      rsp_valid && (rsp_kind == KIND_MASK) && (rsp_bank == BANK_HIGH),
      "high bank mask did not follow low bank")

endmodule

/* design/mngt_front.sv */
// ----------------------------------------------------------------------------
// MIDI note gate timers: front end
// Accepts request items, drops out-of-range plays, clamps durations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mngt_front
   import mngt_pkg::*;
#(
   parameter int NOTE_COUNT = NOTE_COUNT_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  logic [NOTE_FIELD_BITS-1:0] req_note,
   input  logic [DURATION_BITS-1:0]   req_duration,
   input  logic [ELAPSED_BITS-1:0]    req_elapsed,
   output logic                       cmd_valid,
   input  logic                       cmd_ready,
   output cmd_type                    cmd
);

   localparam int NW1   = NOTE_FIELD_BITS + 1;
   localparam int SAT_W = (TIME_BITS > DURATION_BITS) ? TIME_BITS : DURATION_BITS;

   logic             vld_ff, vld_in;
   cmd_type          cmd_ff, cmd_in;
   logic             accept, keep, in_range;
   logic [SAT_W-1:0] dur_ext, tmax_ext, dur_sat;

   assign req_ready = !vld_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign in_range  = NW1'(req_note) < NW1'(NOTE_COUNT);
   assign keep      = (req_action == ACTION_TICK) || in_range;

   assign dur_ext  = SAT_W'(req_duration);
   assign tmax_ext = SAT_W'({TIME_BITS{1'b1}});
   assign dur_sat  = (dur_ext > tmax_ext) ? tmax_ext : dur_ext;

   always_comb begin
      vld_in = vld_ff;
      cmd_in = cmd_ff;
      if (accept) begin
         vld_in           = keep;
         cmd_in.is_tick   = (req_action == ACTION_TICK);
         cmd_in.note      = req_note;
         cmd_in.duration  = CMD_TIME_BITS'(dur_sat);
         cmd_in.elapsed   = req_elapsed;
      end else if (cmd_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = vld_ff;
   assign cmd       = cmd_ff;

endmodule

/* design/mngt_queue.sv */
// ----------------------------------------------------------------------------
// MIDI note gate timers: command queue
// Small FIFO that decouples the front end from the timer engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mngt_queue
   import mngt_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          q_data_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = q_data_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_data_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/mngt_back.sv */
// ----------------------------------------------------------------------------
// MIDI note gate timers: timer engine
// Holds the per-note timer memory, runs plays and tick sweeps, drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mngt_back
   import mngt_pkg::*;
#(
   parameter int NOTE_COUNT = NOTE_COUNT_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  cmd_type                    cmd,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic [NOTE_FIELD_BITS-1:0] rsp_note_number,
   output logic [6:0]                 rsp_velocity,
   output logic                       rsp_bank,
   output logic [MASK_BITS-1:0]       rsp_expired_mask,
   output logic                       rsp_last
);

   localparam int NOTE_W = $clog2(NOTE_COUNT);
   localparam int CMP_W  = (TIME_BITS > ELAPSED_BITS) ? TIME_BITS : ELAPSED_BITS;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_PLAY_RD = 6'b000010,
      ST_PLAY_EX = 6'b000100,
      ST_SWEEP   = 6'b001000,
      ST_BANK_LO = 6'b010000,
      ST_BANK_HI = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;

   logic [NOTE_W-1:0]     cnt_ff, cnt_in;
   logic [NOTE_W-1:0]     wr_idx_ff, wr_idx_in;
   logic                  rd_done_ff, rd_done_in;
   logic                  pend_ff, pend_in;
   logic [MASK_TOTAL-1:0] mask_ff, mask_in;

   // timer store: memory plus a valid bit per note so reset reads as zero
   logic [TIME_BITS-1:0]  timer_mem [NOTE_COUNT];
   logic [NOTE_COUNT-1:0] vld_ff;
   logic [TIME_BITS-1:0]  rd_data_ff;
   logic                  rd_vld_ff;
   logic [NOTE_W-1:0]     rd_addr, wr_addr;
   logic                  wr_en;
   logic [TIME_BITS-1:0]  wr_data;

   logic [TIME_BITS-1:0] timer_cur, dur_t, tick_new;
   logic [CMP_W-1:0]     t_ext, e_ext;
   logic                 expired;
   logic [NOTE_W-1:0]    note_idx;

   // result register
   logic                       out_vld_ff, out_vld_in, out_load, out_free;
   logic                       out_kind_ff, out_kind_in;
   logic [NOTE_FIELD_BITS-1:0] out_note_ff, out_note_in;
   logic [6:0]                 out_vel_ff, out_vel_in;
   logic                       out_bank_ff, out_bank_in;
   logic [MASK_BITS-1:0]       out_mask_ff, out_mask_in;
   logic                       out_last_ff, out_last_in;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign timer_cur = rd_vld_ff ? rd_data_ff : '0;
   assign dur_t     = cmd_ff.duration[TIME_BITS-1:0];
   assign note_idx  = cmd_ff.note[NOTE_W-1:0];
   assign t_ext     = CMP_W'(timer_cur);
   assign e_ext     = CMP_W'(cmd_ff.elapsed);
   assign tick_new  = (t_ext > e_ext) ? TIME_BITS'(t_ext - e_ext) : '0;
   assign expired   = (timer_cur != '0) && (t_ext <= e_ext);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      wr_idx_in   = wr_idx_ff;
      rd_done_in  = rd_done_ff;
      pend_in     = pend_ff;
      mask_in     = mask_ff;
      rd_addr     = cnt_ff;
      wr_en       = 1'b0;
      wr_addr     = wr_idx_ff;
      wr_data     = tick_new;
      cmd_ready   = 1'b0;
      out_load    = 1'b0;
      out_kind_in = KIND_MASK;
      out_note_in = '0;
      out_vel_in  = '0;
      out_bank_in = BANK_LOW;
      out_mask_in = '0;
      out_last_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               if (cmd.is_tick) begin
                  state_in   = ST_SWEEP;
                  cnt_in     = '0;
                  rd_done_in = 1'b0;
                  pend_in    = 1'b0;
                  mask_in    = '0;
               end else begin
                  state_in = ST_PLAY_RD;
               end
            end
         end
         ST_PLAY_RD: begin
            rd_addr  = note_idx;
            state_in = ST_PLAY_EX;
         end
         ST_PLAY_EX: begin
            // keep re-reading the same entry while the result slot is busy
            rd_addr = note_idx;
            if (out_free) begin
               wr_en   = (timer_cur < dur_t);
               wr_addr = note_idx;
               wr_data = dur_t;
               if (timer_cur == '0) begin
                  out_load    = 1'b1;
                  out_kind_in = KIND_NOTE_ON;
                  out_note_in = cmd_ff.note;
                  out_vel_in  = NOTE_VELOCITY;
                  out_last_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            // read note i while writing back note i-1
            if (pend_ff) begin
               wr_en = 1'b1;
               if (expired) begin
                  mask_in[NOTE_FIELD_BITS'(wr_idx_ff)] = 1'b1;
               end
            end
            if (!rd_done_ff) begin
               pend_in   = 1'b1;
               wr_idx_in = cnt_ff;
               if (cnt_ff == NOTE_W'(NOTE_COUNT - 1)) begin
                  rd_done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_BANK_LO;
               end
            end
         end
         ST_BANK_LO: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_bank_in = BANK_LOW;
               out_mask_in = mask_ff[MASK_BITS-1:0];
               state_in    = ST_BANK_HI;
            end
         end
         ST_BANK_HI: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_bank_in = BANK_HIGH;
               out_mask_in = mask_ff[MASK_TOTAL-1:MASK_BITS];
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_done_ff <= 1'b0;
         pend_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
         vld_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         rd_done_ff <= rd_done_in;
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      cnt_ff     <= cnt_in;
      wr_idx_ff  <= wr_idx_in;
      mask_ff    <= mask_in;
      rd_vld_ff  <= vld_ff[rd_addr];
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_note_ff <= out_note_in;
         out_vel_ff  <= out_vel_in;
         out_bank_ff <= out_bank_in;
         out_mask_ff <= out_mask_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= timer_mem[rd_addr];
      if (wr_en) begin
         timer_mem[wr_addr] <= wr_data;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_note_number  = out_note_ff;
   assign rsp_velocity     = out_vel_ff;
   assign rsp_bank         = out_bank_ff;
   assign rsp_expired_mask = out_mask_ff;
   assign rsp_last         = out_last_ff;

endmodule

/* sim/midi_note_gate_timers_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note gate timers: testbench
// Plays notes and sends ticks through the request channel, tracks every note
// timer on the side and checks each note-on and expiry mask that comes back.
// ----------------------------------------------------------------------------

module midi_note_gate_timers_test;
   import mngt_pkg::*;

   localparam logic [31:0] TIMER_LIMIT = 32'((64'd1 << TIME_BITS_DEF) - 64'd1);

   // one result item as seen on the rsp_ port
   typedef struct packed {
      logic                       kind;
      logic [NOTE_FIELD_BITS-1:0] note_number;
      logic [6:0]                 velocity;
      logic                       bank;
      logic [MASK_BITS-1:0]       expired_mask;
      logic                       last;
   } gate_result_type;

   // receiver behavior, picked anew at random by the stall process below
   typedef enum logic [1:0] {RSP_FREE, RSP_COIN, RSP_HOLD} rsp_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_action = ACTION_PLAY;
   logic [NOTE_FIELD_BITS-1:0] req_note = '0;
   logic [DURATION_BITS-1:0]   req_duration = '0;
   logic [ELAPSED_BITS-1:0]    req_elapsed = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_kind;
   logic [NOTE_FIELD_BITS-1:0] rsp_note_number;
   logic [6:0]                 rsp_velocity;
   logic                       rsp_bank;
   logic [MASK_BITS-1:0]       rsp_expired_mask;
   logic                       rsp_last;

   // side copy of the per-note remaining times
   logic [TIME_BITS_DEF-1:0] note_time_left [NOTE_COUNT_DEF];
   // note-ons and masks still owed by the block, oldest first
   gate_result_type results_due [$];

   int unsigned  error_count = 0;
   int unsigned  burst_left  = 0;
   int unsigned  hold_left   = 0;
   rsp_mode_type rsp_mode    = RSP_FREE;

   midi_note_gate_timers dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_note         (req_note),
      .req_duration     (req_duration),
      .req_elapsed      (req_elapsed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_note_number  (rsp_note_number),
      .rsp_velocity     (rsp_velocity),
      .rsp_bank         (rsp_bank),
      .rsp_expired_mask (rsp_expired_mask),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hang guard: far above the slowest legal run (every item a full sweep
   // with both masks held back by the longest receiver stall).
   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Timer tracking: works out what each accepted item must produce
   // ------------------------------------------------------------------------
   task automatic track_item(input logic action, input logic [6:0] note,
                             input logic [23:0] duration, input logic [15:0] elapsed);
      logic [31:0]  want_time;
      logic [31:0]  left;
      logic [127:0] expired;
      begin
         expired = '0;
         if (action == ACTION_PLAY) begin
            // notes past the table are dropped without a trace
            if (note < NOTE_COUNT_DEF) begin
               want_time = 32'(duration);
               if (want_time > TIMER_LIMIT)
                  want_time = TIMER_LIMIT;
               // only a silent note gets a note-on; a sounding one just may grow
               if (note_time_left[note] == '0)
                  results_due.push_back('{KIND_NOTE_ON, note, NOTE_VELOCITY, BANK_LOW,
                                          64'd0, 1'b1});
               if (note_time_left[note] < want_time)
                  note_time_left[note] = want_time[TIME_BITS_DEF-1:0];
            end
         end else begin
            for (int i = 0; i < NOTE_COUNT_DEF; i++) begin
               left = 32'(note_time_left[i]);
               if (left != 0) begin
                  left = (left > elapsed) ? left - elapsed : 32'd0;
                  note_time_left[i] = left[TIME_BITS_DEF-1:0];
                  if (left == 0)
                     expired[i] = 1'b1;
               end
            end
            // a tick always answers with both halves, low notes first
            results_due.push_back('{KIND_MASK, 7'd0, 7'd0, BANK_LOW, expired[63:0], 1'b0});
            results_due.push_back('{KIND_MASK, 7'd0, 7'd0, BANK_HIGH, expired[127:64], 1'b1});
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Sends one item. Items go out in bursts; between bursts valid drops for a
   // random gap, sometimes long enough to land in the middle of a sweep.
   task automatic drive_request(input logic action, input logic [6:0] note,
                                input logic [23:0] duration, input logic [15:0] elapsed);
      int unsigned gap;
      begin
         if (burst_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2: gap = 0;
               3:       gap = $urandom_range(40, 160);
               default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         @(negedge clock);
         req_valid    <= 1'b1;
         req_action   <= action;
         req_note     <= note;
         req_duration <= duration;
         req_elapsed  <= elapsed;
         do @(posedge clock); while (!req_ready);
         track_item(action, note, duration, elapsed);
      end
   endtask

   // Drop valid and hold off until the block owes nothing more.
   task automatic wait_results_drained();
      begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (results_due.size() != 0)
            @(posedge clock);
      end
   endtask

   // One random item. Durations stay short mostly so that notes do expire;
   // a few take the whole range. Fields that the item does not use are random.
   task automatic drive_random_item(input int unsigned tick_pct,
                                    input int unsigned note_lo, input int unsigned note_hi);
      logic [23:0] duration;
      logic [15:0] elapsed;
      int unsigned pick;
      begin
         pick = $urandom_range(0, 99);
         if (pick < 1)
            duration = 24'($urandom);
         else if (pick < 7)
            duration = '0;
         else
            duration = 24'($urandom_range(1, 1500));
         pick = $urandom_range(0, 99);
         if (pick < 5)
            elapsed = '0;
         else if (pick < 10)
            elapsed = 16'($urandom);
         else
            elapsed = 16'($urandom_range(1, 400));
         if ($urandom_range(0, 99) < tick_pct)
            drive_request(ACTION_TICK, 7'($urandom), 24'($urandom), elapsed);
         else
            drive_request(ACTION_PLAY, 7'($urandom_range(note_lo, note_hi)), duration,
                          16'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------
   // Receiver stalls on its own schedule: free-running, coin flip, or held.
   always @(negedge clock) begin
      if (hold_left == 0) begin
         rsp_mode  <= rsp_mode_type'($urandom_range(0, 2));
         hold_left <= $urandom_range(5, 40);
      end else begin
         hold_left <= hold_left - 1;
      end
      case (rsp_mode)
         RSP_FREE: rsp_ready <= 1'b1;
         RSP_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default:  rsp_ready <= 1'b0;
      endcase
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      begin
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      gate_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $error("result item with none outstanding: kind %0b mask %0h",
                   rsp_kind, rsp_expired_mask);
            error_count++;
         end else begin
            want = results_due.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_kind));
            check_field("note_number", 64'(want.note_number), 64'(rsp_note_number));
            check_field("velocity", 64'(want.velocity), 64'(rsp_velocity));
            check_field("bank", 64'(want.bank), 64'(rsp_bank));
            check_field("expired_mask", want.expired_mask, rsp_expired_mask);
            check_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Note-on rules: silent vs sounding notes, zero duration, extreme fields.
   task automatic test_note_on_rules();
      begin
         drive_request(ACTION_PLAY, 7'd0,   24'hFFFFFF, 16'hFFFF);
         drive_request(ACTION_PLAY, 7'd127, 24'd3,      16'h0000);
         // zero length: note-on, timer stays silent, so a replay sounds again
         drive_request(ACTION_PLAY, 7'd64,  24'd0,      16'd0);
         drive_request(ACTION_PLAY, 7'd64,  24'd0,      16'd0);
         // sounding notes 0 and 127: no result, a timer only grows; silent note 63 sounds
         drive_request(ACTION_PLAY, 7'd0,   24'd5,      16'd0);
         drive_request(ACTION_PLAY, 7'd127, 24'd10,     16'd0);
         drive_request(ACTION_PLAY, 7'd63,  24'h000001, 16'd0);
      end
   endtask

   // Tick handling: zero elapsed, exact expiry, saturation, both banks.
   task automatic test_tick_expiry();
      begin
         drive_request(ACTION_TICK, 7'd0,   24'd0,      16'd0);
         drive_request(ACTION_TICK, 7'd127, 24'hFFFFFF, 16'd1);
         drive_request(ACTION_PLAY, 7'd63,  24'h555555, 16'd0);
         drive_request(ACTION_PLAY, 7'd1,   24'hAAAAAA, 16'd0);
         drive_request(ACTION_TICK, 7'd0,   24'd0,      16'd9);
         drive_request(ACTION_PLAY, 7'd127, 24'd2,      16'd0);
         drive_request(ACTION_TICK, 7'd0,   24'd0,      16'hFFFF);
         drive_request(ACTION_TICK, 7'd0,   24'd0,      16'hAAAA);
         drive_request(ACTION_TICK, 7'd0,   24'd0,      16'h5555);
         drive_request(ACTION_PLAY, 7'd42,  24'h800000, 16'd0);
         drive_request(ACTION_PLAY, 7'd85,  24'd7,      16'd0);
         drive_request(ACTION_TICK, 7'd0,   24'd0,      16'd7);
      end
   endtask

   // Broad random traffic over the whole note range.
   task automatic test_random_traffic();
      begin
         repeat (600) drive_random_item(30, 0, 127);
      end
   endtask

   // Sender stops until the block is fully drained, then resumes.
   task automatic test_drain_pause();
      begin
         repeat (2) begin
            repeat (50) drive_random_item(35, 0, 127);
            wait_results_drained();
         end
      end
   endtask

   // Few notes hit hard: replays while sounding, frequent expiries.
   task automatic test_crowded_notes();
      int unsigned base;
      begin
         base = $urandom_range(0, 120);
         repeat (300) drive_random_item(40, base, base + 7);
      end
   endtask

   initial begin
      foreach (note_time_left[i])
         note_time_left[i] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_note_on_rules();
      test_tick_expiry();
      test_random_traffic();
      test_drain_pause();
      test_crowded_notes();

      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      // plays that owe nothing may still be queued behind a sweep
      repeat (400) @(posedge clock);

      if (error_count == 0 && results_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/mngt_pkg.sv
design/mngt_front.sv
design/mngt_queue.sv
design/mngt_back.sv
design/midi_note_gate_timers.sv
sim/midi_note_gate_timers_test.sv
